// File: rtl/core/gmdc_pkg.sv
`default_nettype none

package gmdc_pkg;

    localparam int GRID_MAX_DEF = 32;

    localparam int SIZE_W  = 6;
    localparam int COORD_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd2;

    localparam logic [SIZE_W-1:0]  GRID_SIZE_RST = 6'd8;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_EAST  = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MARK,
        ST_PROBE,
        ST_POP
    } t_state;

    typedef struct packed {
        logic sel_in;
        logic start;
        logic clr;
        logic mark;
        logic rd_visit;
        logic push;
        logic block;
        logic pop;
        logic load_top;
    } t_cmd;

    typedef struct packed {
        logic step_ok;
        logic nb_inside;
        logic visited;
        logic blk_full;
        logic clr_last;
        logic out_wait;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/core/gmdc_ram.sv
`default_nettype none

module gmdc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/gmdc_ctrl.sv
`default_nettype none

module gmdc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_operation,
    output logic                   o_in_stall,
    input  wire gmdc_pkg::t_status i_status,
    output gmdc_pkg::t_cmd         o_cmd
);

    gmdc_pkg::t_state r_state;
    gmdc_pkg::t_state n_state;
    logic             w_accept;

    assign o_in_stall = (r_state != gmdc_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gmdc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gmdc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_operation == gmdc_pkg::OP_START) begin
                        n_state = gmdc_pkg::ST_CLEAR;
                    end else if (i_status.step_ok) begin
                        if (i_status.nb_inside) begin
                            n_state = gmdc_pkg::ST_PROBE;
                        end else if (i_status.blk_full) begin
                            n_state = gmdc_pkg::ST_POP;
                        end
                    end
                end
            end
            gmdc_pkg::ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = gmdc_pkg::ST_MARK;
                end
            end
            gmdc_pkg::ST_MARK: begin
                n_state = gmdc_pkg::ST_IDLE;
            end
            gmdc_pkg::ST_PROBE: begin
                if (i_status.visited) begin
                    n_state = i_status.blk_full ? gmdc_pkg::ST_POP : gmdc_pkg::ST_IDLE;
                end else if (!i_status.out_wait) begin
                    n_state = gmdc_pkg::ST_IDLE;
                end
            end
            gmdc_pkg::ST_POP: begin
                n_state = gmdc_pkg::ST_IDLE;
            end
            default: begin
                n_state = gmdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            gmdc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_operation == gmdc_pkg::OP_START) begin
                        o_cmd.start = 1'b1;
                    end else if (i_status.step_ok) begin
                        o_cmd.sel_in = 1'b1;
                        if (i_status.nb_inside) begin
                            o_cmd.rd_visit = 1'b1;
                        end else begin
                            o_cmd.block = 1'b1;
                            o_cmd.pop   = i_status.blk_full;
                        end
                    end
                end
            end
            gmdc_pkg::ST_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            gmdc_pkg::ST_MARK: begin
                o_cmd.mark = 1'b1;
            end
            gmdc_pkg::ST_PROBE: begin
                if (i_status.visited) begin
                    o_cmd.block = 1'b1;
                    o_cmd.pop   = i_status.blk_full;
                end else if (!i_status.out_wait) begin
                    o_cmd.push = 1'b1;
                end
            end
            gmdc_pkg::ST_POP: begin
                o_cmd.load_top = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/gmdc_dp.sv
`default_nettype none

module gmdc_dp #(
    parameter int GRID_MAX = gmdc_pkg::GRID_MAX_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [gmdc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [gmdc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic [1:0]                          i_random_direction,
    input  wire gmdc_pkg::t_cmd                      i_cmd,
    output gmdc_pkg::t_status                        o_status,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic      [gmdc_pkg::COORD_W-1:0]        o_from_row,
    output logic      [gmdc_pkg::COORD_W-1:0]        o_from_col,
    output logic      [gmdc_pkg::COORD_W-1:0]        o_to_row,
    output logic      [gmdc_pkg::COORD_W-1:0]        o_to_col,
    output logic                                     o_maze_complete
);

    localparam int RW = $clog2(GRID_MAX);
    localparam int AW = 2 * RW;
    localparam int NW = $clog2(GRID_MAX + 1);
    localparam int DW = $clog2(GRID_MAX * GRID_MAX + 1);
    localparam int CW = gmdc_pkg::COORD_W;

    logic [gmdc_pkg::SIZE_W-1:0]  r_cfg_size;
    logic [CW-1:0]                r_cfg_row;
    logic [CW-1:0]                r_cfg_col;

    logic [NW-1:0]  r_size;
    logic [RW-1:0]  r_top_row;
    logic [RW-1:0]  r_top_col;
    logic [DW-1:0]  r_depth;
    logic [DW-1:0]  r_cells_left;
    logic [3:0]     r_blocked;
    logic [1:0]     r_dir;
    logic [AW-1:0]  r_clr_cnt;

    logic           r_out_valid;
    logic [RW-1:0]  r_out_from_row;
    logic [RW-1:0]  r_out_from_col;
    logic [RW-1:0]  r_out_to_row;
    logic [RW-1:0]  r_out_to_col;
    logic           r_out_complete;

    logic [NW-1:0]  w_size;
    logic [RW-1:0]  w_start_row;
    logic [RW-1:0]  w_start_col;
    logic [DW-1:0]  w_start_cells;
    logic [1:0]     w_dir;
    logic           w_inside;
    logic [RW-1:0]  w_nb_row;
    logic [RW-1:0]  w_nb_col;
    logic [3:0]     w_blk;
    logic [AW-1:0]  w_top_addr;
    logic [AW-1:0]  w_nb_addr;

    logic           w_vis_we;
    logic [AW-1:0]  w_vis_waddr;
    logic [0:0]     w_vis_wdata;
    logic [0:0]     w_vis_rdata;
    logic           w_stk_we;
    logic [AW-1:0]  w_stk_waddr;
    logic [AW-1:0]  w_stk_wdata;
    logic [AW-1:0]  w_stk_raddr;
    logic [AW-1:0]  w_stk_rdata;

    always_comb begin
        if (r_cfg_size == '0) begin
            w_size = NW'(1);
        end else if (int'(r_cfg_size) > GRID_MAX) begin
            w_size = NW'(GRID_MAX);
        end else begin
            w_size = NW'(r_cfg_size);
        end
        if (int'(r_cfg_row) >= int'(w_size)) begin
            w_start_row = RW'(int'(w_size) - 1);
        end else begin
            w_start_row = RW'(r_cfg_row);
        end
        if (int'(r_cfg_col) >= int'(w_size)) begin
            w_start_col = RW'(int'(w_size) - 1);
        end else begin
            w_start_col = RW'(r_cfg_col);
        end
        w_start_cells = DW'(int'(w_size) * int'(w_size) - 1);
    end

    assign w_dir = i_cmd.sel_in ? i_random_direction : r_dir;

    always_comb begin
        w_inside = 1'b1;
        w_nb_row = r_top_row;
        w_nb_col = r_top_col;
        case (w_dir)
            gmdc_pkg::DIR_NORTH: begin
                w_inside = (r_top_row != '0);
                w_nb_row = r_top_row - RW'(1);
            end
            gmdc_pkg::DIR_SOUTH: begin
                w_inside = (int'(r_top_row) + 1 < int'(r_size));
                w_nb_row = r_top_row + RW'(1);
            end
            gmdc_pkg::DIR_EAST: begin
                w_inside = (int'(r_top_col) + 1 < int'(r_size));
                w_nb_col = r_top_col + RW'(1);
            end
            default: begin
                w_inside = (r_top_col != '0);
                w_nb_col = r_top_col - RW'(1);
            end
        endcase
    end

    assign w_blk      = r_blocked | (4'b0001 << w_dir);
    assign w_top_addr = {r_top_row, r_top_col};
    assign w_nb_addr  = {w_nb_row, w_nb_col};

    assign o_status.step_ok   = (r_cells_left != '0) && (r_depth != '0);
    assign o_status.nb_inside = w_inside;
    assign o_status.visited   = w_vis_rdata[0];
    assign o_status.blk_full  = &w_blk;
    assign o_status.clr_last  = &r_clr_cnt;
    assign o_status.out_wait  = r_out_valid && i_out_stall;

    assign w_vis_we    = i_cmd.clr || i_cmd.mark || i_cmd.push;
    assign w_vis_waddr = i_cmd.clr ? r_clr_cnt : (i_cmd.mark ? w_top_addr : w_nb_addr);
    assign w_vis_wdata = i_cmd.clr ? 1'b0 : 1'b1;

    assign w_stk_we    = i_cmd.mark || i_cmd.push;
    assign w_stk_waddr = i_cmd.mark ? '0 : AW'(r_depth);
    assign w_stk_wdata = i_cmd.mark ? w_top_addr : w_nb_addr;
    assign w_stk_raddr = AW'(r_depth - DW'(2));

    gmdc_ram #(
        .WIDTH (1),
        .DEPTH (2 ** AW)
    ) u_visited (
        .i_clk   (i_clk),
        .i_we    (w_vis_we),
        .i_waddr (w_vis_waddr),
        .i_wdata (w_vis_wdata),
        .i_re    (i_cmd.rd_visit),
        .i_raddr (w_nb_addr),
        .o_rdata (w_vis_rdata)
    );

    gmdc_ram #(
        .WIDTH (AW),
        .DEPTH (2 ** AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_re    (i_cmd.pop),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_size <= gmdc_pkg::GRID_SIZE_RST;
            r_cfg_row  <= '0;
            r_cfg_col  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gmdc_pkg::CFG_GRID_SIZE: r_cfg_size <= i_cfg_data;
                gmdc_pkg::CFG_START_ROW: r_cfg_row  <= i_cfg_data[CW-1:0];
                gmdc_pkg::CFG_START_COL: r_cfg_col  <= i_cfg_data[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= '0;
            r_cells_left <= '0;
            r_blocked    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_depth      <= DW'(1);
                r_cells_left <= w_start_cells;
                r_blocked    <= '0;
            end else if (i_cmd.push) begin
                r_depth      <= r_depth + DW'(1);
                r_cells_left <= r_cells_left - DW'(1);
                r_blocked    <= '0;
            end else if (i_cmd.pop) begin
                r_depth      <= r_depth - DW'(1);
                r_blocked    <= '0;
            end else if (i_cmd.block) begin
                r_blocked    <= w_blk;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sel_in) begin
            r_dir <= i_random_direction;
        end
        if (i_cmd.start) begin
            r_size    <= w_size;
            r_top_row <= w_start_row;
            r_top_col <= w_start_col;
            r_clr_cnt <= '0;
        end else if (i_cmd.push) begin
            r_top_row <= w_nb_row;
            r_top_col <= w_nb_col;
        end else if (i_cmd.load_top) begin
            r_top_row <= w_stk_rdata[AW-1:RW];
            r_top_col <= w_stk_rdata[RW-1:0];
        end
        if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
        if (i_cmd.push) begin
            r_out_from_row <= r_top_row;
            r_out_from_col <= r_top_col;
            r_out_to_row   <= w_nb_row;
            r_out_to_col   <= w_nb_col;
            r_out_complete <= (r_cells_left == DW'(1));
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_from_row      = CW'(r_out_from_row);
    assign o_from_col      = CW'(r_out_from_col);
    assign o_to_row        = CW'(r_out_to_row);
    assign o_to_col        = CW'(r_out_to_col);
    assign o_maze_complete = r_out_complete;

endmodule

`default_nettype wire

// File: rtl/core/grid_maze_dfs_carver.sv
// Grid maze carver: builds an n-by-n maze by randomized depth-first search.
// Requests arrive on the input channel (i_in_valid, o_in_stall) with an
// operation and a random direction. A start request latches the grid size
// and start cell from the configuration registers in its accept cycle, then
// sweeps the whole visited memory (2**(2*clog2(GRID_MAX)) entries, 1024 at the
// default) and then marks the start cell; it gives no result.
// A step request tries one direction from the cell on top of the path stack.
// A direction outside the grid is blocked in the accept cycle; a neighbor inside
// the grid moves on to the probe state for the registered read of its visited
// bit; a stack pop adds the pop state to read the new top. A new wall goes to
// the output register (o_out_valid, i_out_stall) and is shown on the cycle
// after the step finishes. The next request is taken while a wall waits in
// the output register; a step that would produce a second wall holds until
// the first is taken, so nothing is dropped while the receiver stalls.
// Reset returns the configuration registers to their defaults and empties
// the stack, so steps produce nothing until the first start request.
`default_nettype none

module grid_maze_dfs_carver #(
    parameter int GRID_MAX = gmdc_pkg::GRID_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gmdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gmdc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_operation,
    input  wire logic [1:0]                      i_random_direction,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [gmdc_pkg::COORD_W-1:0]    o_from_row,
    output logic      [gmdc_pkg::COORD_W-1:0]    o_from_col,
    output logic      [gmdc_pkg::COORD_W-1:0]    o_to_row,
    output logic      [gmdc_pkg::COORD_W-1:0]    o_to_col,
    output logic                                 o_maze_complete
);

    gmdc_pkg::t_cmd    w_cmd;
    gmdc_pkg::t_status w_status;

    gmdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    gmdc_dp #(
        .GRID_MAX (GRID_MAX)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_random_direction (i_random_direction),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_from_row         (o_from_row),
        .o_from_col         (o_from_col),
        .o_to_row           (o_to_row),
        .o_to_col           (o_to_col),
        .o_maze_complete    (o_maze_complete)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
package maze_tb_pkg;

    import gmdc_pkg::*;

    localparam int GRID_N = GRID_MAX_DEF;
    localparam int CELLS  = GRID_N * GRID_N;

    typedef struct packed {
        logic [COORD_W-1:0] from_row;
        logic [COORD_W-1:0] from_col;
        logic [COORD_W-1:0] to_row;
        logic [COORD_W-1:0] to_col;
        logic               complete;
    } t_wall;

    class wall_scoreboard;
        logic [SIZE_W-1:0]  size_reg;
        logic [COORD_W-1:0] row_reg;
        logic [COORD_W-1:0] col_reg;
        bit                 visited [CELLS];
        int unsigned        path [CELLS];
        int unsigned        depth;
        int unsigned        cells_left;
        int unsigned        active_n;
        logic [3:0]         blocked;
        t_wall              walls_due [$];
        int                 errors;

        function new();
            size_reg   = GRID_SIZE_RST;
            row_reg    = '0;
            col_reg    = '0;
            visited    = '{default: 0};
            path       = '{default: 0};
            depth      = 0;
            cells_left = 0;
            active_n   = 1;
            blocked    = '0;
            errors     = 0;
        endfunction

        function int pending();
            return walls_due.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GRID_SIZE: size_reg = data[SIZE_W-1:0];
                CFG_START_ROW: row_reg = data[COORD_W-1:0];
                CFG_START_COL: col_reg = data[COORD_W-1:0];
                default: ;
            endcase
        endfunction

        // Returns 1 when the request can change the maze, 0 when it is ignored.
        function bit note_request(logic op, logic [1:0] dir);
            int unsigned top;
            int unsigned r;
            int unsigned c;
            int unsigned nr;
            int unsigned nc;
            int unsigned cell_id;
            bit          in_grid;
            t_wall       wall;
            if (op == OP_START) begin
                active_n = (size_reg == 0) ? 1 : (size_reg > GRID_N) ? GRID_N : size_reg;
                r = (row_reg >= active_n) ? active_n - 1 : row_reg;
                c = (col_reg >= active_n) ? active_n - 1 : col_reg;
                visited = '{default: 0};
                cell_id = r * GRID_N + c;
                visited[cell_id] = 1;
                path[0] = cell_id;
                depth = 1;
                blocked = '0;
                cells_left = active_n * active_n - 1;
                return 1;
            end
            if (cells_left == 0 || depth == 0) begin
                return 0;
            end
            top = path[depth - 1];
            r = top / GRID_N;
            c = top % GRID_N;
            nr = r;
            nc = c;
            in_grid = 1;
            case (dir)
                DIR_NORTH: if (r == 0) in_grid = 0; else nr = r - 1;
                DIR_SOUTH: if (r + 1 >= active_n) in_grid = 0; else nr = r + 1;
                DIR_EAST:  if (c + 1 >= active_n) in_grid = 0; else nc = c + 1;
                default:   if (c == 0) in_grid = 0; else nc = c - 1;
            endcase
            cell_id = nr * GRID_N + nc;
            if (in_grid && !visited[cell_id]) begin
                visited[cell_id] = 1;
                path[depth] = cell_id;
                depth++;
                blocked = '0;
                cells_left--;
                wall.from_row = r[COORD_W-1:0];
                wall.from_col = c[COORD_W-1:0];
                wall.to_row   = nr[COORD_W-1:0];
                wall.to_col   = nc[COORD_W-1:0];
                wall.complete = (cells_left == 0);
                walls_due = {walls_due, wall};
                return 1;
            end
            blocked = blocked | (4'b0001 << dir);
            if (blocked == 4'hF) begin
                depth--;
                blocked = '0;
            end
            return 1;
        endfunction

        task report_mismatch(string msg);
            if (errors < 100) begin
                $display("mismatch: %s", msg);
            end
            errors++;
        endtask

        task check_result(t_wall got);
            t_wall want;
            if (walls_due.size() == 0) begin
                report_mismatch($sformatf("unexpected wall (%0d,%0d)->(%0d,%0d)",
                    got.from_row, got.from_col, got.to_row, got.to_col));
                return;
            end
            want = walls_due.pop_front();
            if (got.from_row !== want.from_row) begin
                report_mismatch($sformatf("from_row %0d, expected %0d",
                    got.from_row, want.from_row));
            end
            if (got.from_col !== want.from_col) begin
                report_mismatch($sformatf("from_col %0d, expected %0d",
                    got.from_col, want.from_col));
            end
            if (got.to_row !== want.to_row) begin
                report_mismatch($sformatf("to_row %0d, expected %0d", got.to_row, want.to_row));
            end
            if (got.to_col !== want.to_col) begin
                report_mismatch($sformatf("to_col %0d, expected %0d", got.to_col, want.to_col));
            end
            if (got.complete !== want.complete) begin
                report_mismatch($sformatf("maze_complete %0b, expected %0b",
                    got.complete, want.complete));
            end
        endtask
    endclass

endpackage

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import gmdc_pkg::*;
    import maze_tb_pkg::*;

    localparam int SETTLE_CYCLES = CELLS + 64;
    localparam int RANDOM_ITEMS  = 950;
    localparam int CALM_FROM     = 820;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_operation;
    logic [1:0]            i_random_direction;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [COORD_W-1:0]    o_from_row;
    logic [COORD_W-1:0]    o_from_col;
    logic [COORD_W-1:0]    o_to_row;
    logic [COORD_W-1:0]    o_to_col;
    logic                  o_maze_complete;

    wall_scoreboard sb = new();
    bit             calm = 0;
    int             live_items = 0;

    grid_maze_dfs_carver u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_random_direction (i_random_direction),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_from_row         (o_from_row),
        .o_from_col         (o_from_col),
        .o_to_row           (o_to_row),
        .o_to_col           (o_to_col),
        .o_maze_complete    (o_maze_complete)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && stall_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 5);
            end
            if (calm) begin
                stall_left = 0;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_wall got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got.from_row = o_from_row;
            got.from_col = o_from_col;
            got.to_row   = o_to_row;
            got.to_col   = o_to_col;
            got.complete = o_maze_complete;
            sb.check_result(got);
        end
    end

    task automatic send_request(input logic op, input logic [1:0] dir);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_operation        <= op;
        i_random_direction <= dir;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        void'(sb.note_request(op, dir));
        live_items++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_settings(input logic [5:0] size, input logic [4:0] row,
                                  input logic [4:0] col);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx = '{CFG_GRID_SIZE, CFG_START_ROW, CFG_START_COL};
        val = '{size, {1'b0, row}, {1'b0, col}};
        for (int k = 0; k < 3; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            sb.write_reg(idx[k], val[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int   n;
        int   steps;
        int   cap;
        logic [5:0] size;
        logic [4:0] row;
        logic [4:0] col;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= CFG_GRID_SIZE;
        i_cfg_data         <= '0;
        i_in_valid         <= 1'b0;
        i_operation        <= OP_STEP;
        i_random_direction <= DIR_NORTH;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Steps with no maze started must be ignored.
        send_request(OP_STEP, DIR_NORTH);
        send_request(OP_STEP, DIR_SOUTH);
        send_request(OP_STEP, DIR_EAST);
        send_request(OP_STEP, DIR_WEST);

        settle();
        write_settings(6'd1, 5'd0, 5'd0);
        send_request(OP_START, DIR_NORTH);
        send_request(OP_STEP, DIR_NORTH);
        send_request(OP_STEP, DIR_SOUTH);
        send_request(OP_STEP, DIR_EAST);
        send_request(OP_STEP, DIR_WEST);

        settle();
        write_settings(6'd0, 5'd0, 5'd0);
        send_request(OP_START, DIR_WEST);
        send_request(OP_STEP, DIR_EAST);

        // The start cell saturates to the far corner; the third wall completes the maze.
        settle();
        write_settings(6'd2, 5'd31, 5'd31);
        send_request(OP_START, DIR_EAST);
        send_request(OP_STEP, DIR_NORTH);
        send_request(OP_STEP, DIR_WEST);
        send_request(OP_STEP, DIR_SOUTH);
        send_request(OP_STEP, DIR_EAST);

        settle();
        write_settings(6'd63, 5'd31, 5'd0);
        send_request(OP_START, DIR_SOUTH);
        send_request(OP_STEP, DIR_SOUTH);
        send_request(OP_STEP, DIR_WEST);
        send_request(OP_STEP, DIR_EAST);
        send_request(OP_STEP, DIR_NORTH);

        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            settle();
            calm = (live_items >= CALM_FROM) || ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0:       size = 6'd0;
                1:       size = 6'd63;
                2:       size = 6'd32;
                3, 4, 5: size = 6'($urandom_range(9, 31));
                default: size = 6'($urandom_range(1, 8));
            endcase
            n = (size == 0) ? 1 : (size > GRID_N) ? GRID_N : size;
            if ($urandom_range(0, 5) == 0) begin
                row = 5'($urandom_range(0, 31));
                col = 5'($urandom_range(0, 31));
            end else begin
                row = 5'($urandom_range(0, n - 1));
                col = 5'($urandom_range(0, n - 1));
            end
            write_settings(size, row, col);
            // Now and then the old maze goes on under the new settings.
            if ($urandom_range(0, 4) != 0) begin
                send_request(OP_START, 2'($urandom_range(0, 3)));
            end
            cap = n * n * 6;
            if (cap > 150) cap = 150;
            if (cap < 8) cap = 8;
            steps = $urandom_range(4, cap);
            for (int k = 0; k < steps; k++) begin
                if ($urandom_range(0, 39) == 0) begin
                    send_request(OP_START, 2'($urandom_range(0, 3)));
                end else begin
                    send_request(OP_STEP, 2'($urandom_range(0, 3)));
                end
            end
        end

        calm = 1;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
